// ===== rtl/crc32c_word_list_checker_macros.svh =====
// ----------------------------------------------------------------------------
// crc32c word list checker assertion macros
// shared property wrappers, sampled on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef CRC32C_WORD_LIST_CHECKER_MACROS_SVH
`define CRC32C_WORD_LIST_CHECKER_MACROS_SVH

// condition holds at every edge out of reset
`define CWLC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// trigger in one cycle implies the effect in the next
`define CWLC_ASSERT_NEXT(label, trig, effect, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (effect)) \
    else $error(msg);

`endif

// ===== rtl/crc32c_wlc_pkg.sv =====
// ----------------------------------------------------------------------------
// crc32c word list checker package
// beat types, item kinds, sizes and the crc-32c word update
// ----------------------------------------------------------------------------
package crc32c_wlc_pkg;

  localparam int          MAX_CANDIDATES_DEF = 32;
  localparam int          INDEX_LIMIT        = 32;
  localparam int          IDX_W              = 5;
  localparam int          FIFO_DEPTH         = 2;
  localparam logic [31:0] CRC32C_POLY        = 32'h82F6_3B78;

  // input beat as seen on the port
  typedef struct packed {
    logic [31:0] data_word;
    logic        is_checksum_word;
    logic        last_candidate;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic [31:0]      computed_crc;
    logic             crc_match;
    logic             list_done;
    logic             any_match;
    logic [IDX_W-1:0] first_match_index;
  } out_item_t;

  // classification done by the front end
  typedef enum logic [1:0] {
    KIND_DATA       = 2'd0,
    KIND_CHECK      = 2'd1,
    KIND_CHECK_LAST = 2'd2
  } item_kind_t;

  // entry of the queue between front and back
  typedef struct packed {
    item_kind_t  kind;
    logic [31:0] word;
  } q_item_t;

  // crc contribution of a single set bit after one full 32-bit word
  function automatic logic [31:0] crc32c_col(input int unsigned bit_idx);
    logic [31:0] c;
    c = 32'h1 << bit_idx;
    for (int k = 0; k < 32; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC32C_POLY : 32'h0);
    end
    return c;
  endfunction

  // one word of crc-32c, lsb first, as a flat xor network of constant columns
  function automatic logic [31:0] crc32c_word(input logic [31:0] crc,
                                              input logic [31:0] word);
    logic [31:0] v;
    logic [31:0] acc;
    v   = crc ^ word;
    acc = 32'h0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) acc = acc ^ crc32c_col(i);
    end
    return acc;
  endfunction

endpackage

// ===== rtl/crc32c_wlc_fifo.sv =====
// ----------------------------------------------------------------------------
// crc32c word list checker fifo
// short register queue with full and empty flags
// ----------------------------------------------------------------------------
module crc32c_wlc_fifo
  import crc32c_wlc_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(FIFO_DEPTH - 1);

  logic [WIDTH-1:0] mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(FIFO_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop)      count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// ===== rtl/crc32c_wlc_front.sv =====
// ----------------------------------------------------------------------------
// crc32c word list checker front end
// takes input beats, tags them as data or checksum words, queues them
// ----------------------------------------------------------------------------
module crc32c_wlc_front
  import crc32c_wlc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  in_item_t in_item,
  output logic     in_full,
  input  logic     q_pop,
  output q_item_t  q_head,
  output logic     q_empty
);

  q_item_t tagged_item;
  logic [$bits(q_item_t)-1:0] head_bits;

  // classify; the list end flag only counts on a checksum word
  always_comb begin
    tagged_item.word = in_item.data_word;
    if (!in_item.is_checksum_word)   tagged_item.kind = KIND_DATA;
    else if (in_item.last_candidate) tagged_item.kind = KIND_CHECK_LAST;
    else                             tagged_item.kind = KIND_CHECK;
  end

  crc32c_wlc_fifo #(
    .WIDTH ($bits(q_item_t))
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_data (tagged_item),
    .full      (in_full),
    .pop       (q_pop),
    .head      (head_bits),
    .empty     (q_empty)
  );

  assign q_head = q_item_t'(head_bits);

endmodule

// ===== rtl/crc32c_wlc_back.sv =====
// ----------------------------------------------------------------------------
// crc32c word list checker back end
// running crc, candidate list tracking and the result queue
// ----------------------------------------------------------------------------
module crc32c_wlc_back
  import crc32c_wlc_pkg::*;
#(
  parameter int MAX_CANDIDATES = MAX_CANDIDATES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  q_item_t   q_head,
  input  logic      q_empty,
  output logic      q_pop,
  output out_item_t out_item,
  output logic      out_empty,
  input  logic      out_pop
);

`include "crc32c_word_list_checker_macros.svh"

  localparam int BOUND = (MAX_CANDIDATES > INDEX_LIMIT) ? INDEX_LIMIT : MAX_CANDIDATES;
  localparam logic [IDX_W-1:0] COUNT_TOP = IDX_W'(BOUND - 1);

  logic [31:0]      crc_r, crc_nxt;
  logic [IDX_W-1:0] count_r, count_nxt;
  logic             seen_r, seen_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;

  logic             res_full;
  logic             is_check;
  logic             is_last;
  logic             take;
  logic             match;
  logic             seen_cur;
  logic [IDX_W-1:0] pos_cur;
  out_item_t        result;
  logic [$bits(out_item_t)-1:0] res_bits;

  assign is_check = (q_head.kind != KIND_DATA);
  assign is_last  = (q_head.kind == KIND_CHECK_LAST);
  // data words never wait; checksum words need room for their result
  assign take     = !q_empty && (!is_check || !res_full);
  assign q_pop    = take;

  // check against the running crc and fold into the list status
  always_comb begin
    match    = (crc_r == q_head.word);
    seen_cur = seen_r || match;
    pos_cur  = (match && !seen_r) ? count_r : pos_r;
    result.computed_crc      = crc_r;
    result.crc_match         = match;
    result.list_done         = is_last;
    result.any_match         = seen_cur;
    result.first_match_index = pos_cur;
  end

  // state update
  always_comb begin
    crc_nxt   = crc_r;
    count_nxt = count_r;
    seen_nxt  = seen_r;
    pos_nxt   = pos_r;
    if (take) begin
      if (!is_check) begin
        crc_nxt = crc32c_word(crc_r, q_head.word);
      end else begin
        crc_nxt = '0;
        if (is_last) begin
          count_nxt = '0;
          seen_nxt  = 1'b0;
          pos_nxt   = '0;
        end else begin
          if (count_r < COUNT_TOP) count_nxt = count_r + 1'b1;
          seen_nxt = seen_cur;
          pos_nxt  = pos_cur;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= '0;
      count_r <= '0;
      seen_r  <= 1'b0;
      pos_r   <= '0;
    end else begin
      crc_r   <= crc_nxt;
      count_r <= count_nxt;
      seen_r  <= seen_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // result queue decouples the engine from the receiver
  crc32c_wlc_fifo #(
    .WIDTH ($bits(out_item_t))
  ) u_results (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take && is_check),
    .push_data (result),
    .full      (res_full),
    .pop       (out_pop),
    .head      (res_bits),
    .empty     (out_empty)
  );

  assign out_item = out_item_t'(res_bits);

  // checks
  `CWLC_ASSERT_ALWAYS(a_count_bound, count_r <= COUNT_TOP, "candidate count past bound")
  `CWLC_ASSERT_ALWAYS(a_pos_clear, seen_r || (pos_r == '0), "match position set without match")
  `CWLC_ASSERT_NEXT(a_list_end, take && is_last,
                    (count_r == '0) && !seen_r && (crc_r == '0), "list state not cleared")
  `CWLC_ASSERT_NEXT(a_data_count, take && !is_check, $stable(count_r) && $stable(seen_r),
                    "data word changed list state")

endmodule

// ===== rtl/crc32c_word_list_checker.sv =====
// ----------------------------------------------------------------------------
// crc32c word list checker
// crc-32c generation and checking over a list of candidate frames
// ----------------------------------------------------------------------------
// Usage:
//   Input beats are pushed with in_push while in_full is low. A beat is a
//   32-bit word plus flags; a frame is its data words followed by one
//   checksum word, and last_candidate on a checksum word closes the list.
//   Only checksum words give a result beat: the crc over the frame's data
//   words (zero initial value, no final inversion), the match flag, and the
//   first matching candidate of the list so far.
//   Results are read like a queue: while out_empty is low the oldest result
//   is on out_item, and out_pop takes it.
//   A checksum beat is first registered in the input queue; the crc engine
//   then writes its result into the result queue, from which it appears on
//   out_item.
//   Throughput is one word per cycle while the result queue has room; the crc
//   update is a single xor network on the engine's running crc register.
//   A stalled receiver fills the 2-entry result queue; the engine then holds
//   checksum words, the 2-entry input queue fills and in_full rises.
//   Synchronous reset clears both queues, the running crc and list state.
// ----------------------------------------------------------------------------
module crc32c_word_list_checker
  import crc32c_wlc_pkg::*;
#(
  parameter int MAX_CANDIDATES = MAX_CANDIDATES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  in_item_t  in_item,
  output logic      in_full,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  q_item_t q_head;
  logic    q_empty;
  logic    q_pop;

  crc32c_wlc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_item (in_item),
    .in_full (in_full),
    .q_pop   (q_pop),
    .q_head  (q_head),
    .q_empty (q_empty)
  );

  crc32c_wlc_back #(
    .MAX_CANDIDATES (MAX_CANDIDATES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_item  (out_item),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

endmodule

// ===== sim/crc32c_word_list_checker_tb.sv =====
// ----------------------------------------------------------------------------
// crc32c word list checker testbench
// pushes candidate frames (data words, then a checksum word) in lists and
// checks every result beat against a behavioral crc-32c list predictor;
// the sender runs in random bursts, the receiver stalls on a rotating mask
// ----------------------------------------------------------------------------
module crc32c_word_list_checker_tb;
  import crc32c_wlc_pkg::*;

  localparam int          MAX_CAND    = MAX_CANDIDATES_DEF;
  localparam int          ITEM_TARGET = 1650;
  localparam int          IDLE_LIMIT  = 2000;
  localparam int          TAIL_CYCLES = 8;
  localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;

  // one crc-32c word step, lsb first, bit-serial
  function automatic logic [31:0] crc32c_shift_word(input logic [31:0] crc,
                                                    input logic [31:0] word);
    logic [31:0] r;
    r = crc ^ word;
    for (int k = 0; k < 32; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC32C_POLY) : (r >> 1);
    end
    return r;
  endfunction

  // predicted list state and the queue of result beats still owed
  class crc_list_scoreboard;
    out_item_t        owed_q[$];
    logic [31:0]      crc_acc;
    logic [IDX_W-1:0] cand_idx;
    logic [IDX_W-1:0] hit_pos;
    logic             hit_seen;
    int unsigned      idx_top;
    int unsigned      fails;
    int unsigned      results_seen;

    function new(input int unsigned max_cand);
      int unsigned bound;
      bound = (max_cand > INDEX_LIMIT) ? INDEX_LIMIT : max_cand;
      if (bound < 1) bound = 1;
      idx_top      = bound - 1;
      crc_acc      = '0;
      cand_idx     = '0;
      hit_pos      = '0;
      hit_seen     = 1'b0;
      fails        = 0;
      results_seen = 0;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    function void note_fail(input string msg);
      fails++;
      if (fails <= 10) $display("%s", msg);
    endfunction

    // accepted input beat: update the state, queue a result on checksum words
    function void note_word(input in_item_t w);
      out_item_t r;
      if (!w.is_checksum_word) begin
        crc_acc = crc32c_shift_word(crc_acc, w.data_word);
        return;
      end
      r.computed_crc = crc_acc;
      r.crc_match    = (crc_acc == w.data_word);
      if (r.crc_match && !hit_seen) begin
        hit_seen = 1'b1;
        hit_pos  = cand_idx;
      end
      r.list_done         = w.last_candidate;
      r.any_match         = hit_seen;
      r.first_match_index = hit_seen ? hit_pos : '0;
      owed_q.push_back(r);
      crc_acc = '0;
      if (cand_idx < idx_top) cand_idx++;
      if (w.last_candidate) begin
        cand_idx = '0;
        hit_seen = 1'b0;
        hit_pos  = '0;
      end
    endfunction

    // accepted result beat against the oldest owed one
    function void check_result(input out_item_t got);
      out_item_t want;
      bit        bad;
      results_seen++;
      if (owed_q.size() == 0) begin
        note_fail($sformatf("result %0d: unexpected beat crc=%h match=%b done=%b any=%b idx=%0d",
                            results_seen, got.computed_crc, got.crc_match, got.list_done,
                            got.any_match, got.first_match_index));
        return;
      end
      want = owed_q.pop_front();
      bad  = 1'b0;
      if (got.computed_crc !== want.computed_crc)           bad = 1'b1;
      if (got.crc_match !== want.crc_match)                 bad = 1'b1;
      if (got.list_done !== want.list_done)                 bad = 1'b1;
      if (got.any_match !== want.any_match)                 bad = 1'b1;
      if (got.first_match_index !== want.first_match_index) bad = 1'b1;
      if (bad) begin
        note_fail($sformatf({"result %0d: expected crc=%h match=%b done=%b any=%b idx=%0d,",
                             " got crc=%h match=%b done=%b any=%b idx=%0d"},
                            results_seen, want.computed_crc, want.crc_match, want.list_done,
                            want.any_match, want.first_match_index, got.computed_crc,
                            got.crc_match, got.list_done, got.any_match,
                            got.first_match_index));
      end
    endfunction
  endclass

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      in_push = 1'b0;
  in_item_t  in_item = '0;
  logic      in_full;
  logic      out_empty;
  logic      out_pop = 1'b0;
  out_item_t out_item;

  crc_list_scoreboard sb;
  int unsigned        burst_left = 0;
  int unsigned        sent_count = 0;
  logic [31:0]        frame_crc  = '0;

  crc32c_word_list_checker #(
    .MAX_CANDIDATES(MAX_CAND)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .in_full  (in_full),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // one input beat; bursts of random length with random gaps between them
  task automatic send_word(input in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_word(it);
    sent_count++;
  endtask

  // data word of the current frame, tracking its crc for good checksums
  task automatic send_data(input logic [31:0] word, input logic last_flag);
    in_item_t it;
    it.data_word        = word;
    it.is_checksum_word = 1'b0;
    it.last_candidate   = last_flag;
    frame_crc = crc32c_shift_word(frame_crc, word);
    send_word(it);
  endtask

  // checksum word closing the current frame
  task automatic send_check(input logic [31:0] word, input logic last_flag);
    in_item_t it;
    it.data_word        = word;
    it.is_checksum_word = 1'b1;
    it.last_candidate   = last_flag;
    frame_crc = '0;
    send_word(it);
  endtask

  // stop pushing until every owed result beat has been taken
  task automatic hold_until_drained();
    in_push <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [31:0] pick_word();
    int unsigned sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return '0;
    if (sel == 1) return ALL_ONES;
    return $urandom;
  endfunction

  // one random list: mostly short, now and then long enough to pin the index
  task automatic random_list();
    int unsigned n_cand;
    int unsigned n_data;
    int unsigned good_from;
    int unsigned sel;
    bit          long_list;
    logic [31:0] ck;
    long_list = ($urandom_range(0, 14) == 0);
    n_cand    = long_list ? $urandom_range(33, 40) : $urandom_range(1, 6);
    good_from = long_list ? $urandom_range(25, n_cand) : 0;
    for (int unsigned c = 0; c < n_cand; c++) begin
      if (long_list) n_data = $urandom_range(0, 1);
      else if ($urandom_range(0, 9) == 0) n_data = $urandom_range(5, 12);
      else n_data = $urandom_range(0, 3);
      for (int unsigned d = 0; d < n_data; d++) begin
        send_data(pick_word(), ($urandom_range(0, 7) == 0));
      end
      sel = $urandom_range(0, 9);
      if (long_list && c < good_from) ck = frame_crc ^ (32'h1 << $urandom_range(0, 31));
      else if (sel < 4) ck = frame_crc;
      else if (sel < 7) ck = pick_word();
      else ck = frame_crc ^ (32'h1 << $urandom_range(0, 31));
      send_check(ck, (c == n_cand - 1));
    end
  endtask

  // result side: pop on a rotating mask that is reloaded now and then
  initial begin : result_side
    logic [15:0] pat;
    int unsigned phase_left;
    pat        = 16'hFFFF;
    phase_left = 0;
    forever begin
      @(posedge clk);
      if (out_pop && !out_empty) sb.check_result(out_item);
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 80);
        pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(1, 16'hFFFF));
      end
      phase_left--;
      pat = {pat[0], pat[15:1]};
      out_pop <= pat[0] & rst_n;
    end
  end

  // watchdog on cycles with no beat moving on either side
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty)) idle = 0;
      else idle++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    bit paused;
    paused = 1'b0;
    sb = new(MAX_CAND);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty candidates: zero checksum matches, all-ones does not
    send_check('0, 1'b0);
    send_check(ALL_ONES, 1'b1);
    // last flag on a data word is ignored
    send_data(ALL_ONES, 1'b1);
    send_check(frame_crc, 1'b0);
    send_data('0, 1'b0);
    send_data(32'h0000_0001, 1'b0);
    send_check(frame_crc ^ 32'h1, 1'b0);
    send_data(32'h8000_0000, 1'b0);
    send_check(frame_crc, 1'b1);
    // first match on the third candidate
    send_check(32'h0000_0001, 1'b0);
    send_data(32'h1234_5678, 1'b0);
    send_check('0, 1'b0);
    send_check('0, 1'b0);
    send_data(32'hA5A5_A5A5, 1'b0);
    send_check(frame_crc, 1'b1);
    // list with no match at all
    send_data(32'h5A5A_5A5A, 1'b0);
    send_check(frame_crc ^ ALL_ONES, 1'b1);
    hold_until_drained();

    // random lists, with one full drain halfway
    while (sent_count < ITEM_TARGET) begin
      random_list();
      if (!paused && sent_count >= ITEM_TARGET / 2) begin
        hold_until_drained();
        paused = 1'b1;
      end
    end

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
